// ----- design/gtg_pkg.sv -----
// Shared types, constants and the arctangent table of the go-to-goal controller.
// Used by every module of the block; depends on nothing.
package gtg_pkg;

    localparam int HEAD_WIDTH   = 13;
    localparam int TOL_WIDTH    = 15;
    localparam int TURN_WIDTH   = 16;
    localparam int FRAC_BITS    = 10;
    localparam int CORDIC_FRAC  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ZW           = 19;
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    localparam logic [ZW-2:0] PI_Q16      = 18'd205887;
    localparam logic [ZW-2:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [ZW-1:0] ROUND_Q16   = 19'd32;

    typedef enum logic [1:0] {
        REG_DIST_TOL  = 2'd0,
        REG_ANGLE_TOL = 2'd1,
        REG_TURN_SPD  = 2'd2,
        REG_DRV_GAIN  = 2'd3
    } reg_index_t;

    // Flags that ride along with one pose through the pipeline.
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic near;
        logic head_neg;
        logic head_over;
    } gtg_ctl_t;

    // atan(2^-i) in Q.16.
    function automatic logic [ZW-2:0] atan_q16(input int i);
        logic [ZW-2:0] v;
        case (i)
            0:       v = 18'd51472;
            1:       v = 18'd30385;
            2:       v = 18'd16055;
            3:       v = 18'd8150;
            4:       v = 18'd4091;
            5:       v = 18'd2047;
            6:       v = 18'd1024;
            7:       v = 18'd512;
            8:       v = 18'd256;
            9:       v = 18'd128;
            10:      v = 18'd64;
            11:      v = 18'd32;
            12:      v = 18'd16;
            13:      v = 18'd8;
            14:      v = 18'd4;
            15:      v = 18'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/gtg_front.sv -----
// Front end: magnitudes, squares and tolerance tests of one goal pose, two register stages.
// Depends on gtg_pkg.
module gtg_front
    import gtg_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_i,
    output logic                  ready_o,
    input  logic signed [W-1:0]   goal_x,
    input  logic signed [W-1:0]   goal_y,
    input  logic signed [HEAD_WIDTH-1:0] goal_heading,
    input  logic [TOL_WIDTH-1:0]  dist_tol,
    input  logic [TOL_WIDTH-1:0]  angle_tol,
    output logic                  valid_o,
    input  logic                  ready_i,
    output gtg_ctl_t              ctl_o,
    output logic [W-1:0]          ux_o,
    output logic [W-1:0]          uy_o,
    output logic [2*W-1:0]        s_o
);

    localparam int SW = (2*W > 2*TOL_WIDTH) ? 2*W : 2*TOL_WIDTH;

    logic                   v1_reg, v2_reg;
    logic                   en1, en2;
    gtg_ctl_t               ctl1_reg, ctl1_next, ctl2_reg, ctl2_next;
    logic [W-1:0]           ux1_reg, uy1_reg, ux1_next, uy1_next, ux2_reg, uy2_reg;
    logic [2*W-1:0]         xx_reg, yy_reg, s2_reg, s_sum;
    logic [2*TOL_WIDTH-1:0] dt2_reg;
    logic [HEAD_WIDTH-1:0]  ah;

    assign en2     = !v2_reg || ready_i;
    assign en1     = !v1_reg || en2;
    assign ready_o = en1;

    always_comb
    begin
        ux1_next = goal_x[W-1] ? (~goal_x + 1'b1) : goal_x;
        uy1_next = goal_y[W-1] ? (~goal_y + 1'b1) : goal_y;
        ah       = goal_heading[HEAD_WIDTH-1] ? (~goal_heading + 1'b1) : goal_heading;
        ctl1_next.x_neg     = goal_x[W-1];
        ctl1_next.y_neg     = goal_y[W-1];
        ctl1_next.x_zero    = (goal_x == '0);
        ctl1_next.near      = 1'b0;
        ctl1_next.head_neg  = goal_heading[HEAD_WIDTH-1];
        ctl1_next.head_over = {{(TOL_WIDTH-HEAD_WIDTH){1'b0}}, ah} > angle_tol;
    end

    assign s_sum = xx_reg + yy_reg;

    always_comb
    begin
        ctl2_next      = ctl1_reg;
        ctl2_next.near = SW'(s_sum) < SW'(dt2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= valid_i;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && valid_i)
        begin
            ctl1_reg <= ctl1_next;
            ux1_reg  <= ux1_next;
            uy1_reg  <= uy1_next;
            xx_reg   <= ux1_next * ux1_next;
            yy_reg   <= uy1_next * uy1_next;
            dt2_reg  <= dist_tol * dist_tol;
        end
        if (en2 && v1_reg)
        begin
            ctl2_reg <= ctl2_next;
            ux2_reg  <= ux1_reg;
            uy2_reg  <= uy1_reg;
            s2_reg   <= s_sum;
        end
    end

    assign valid_o = v2_reg;
    assign ctl_o   = ctl2_reg;
    assign ux_o    = ux2_reg;
    assign uy_o    = uy2_reg;
    assign s_o     = s2_reg;

endmodule

// ----- design/gtg_cell.sv -----
// One cell of the chain: a CORDIC vectoring step, one digit of one of the two square roots, or both.
// Depends on gtg_pkg.
module gtg_cell
    import gtg_pkg::*;
#(
    parameter int W    = 16,
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_i,
    output logic                         ready_o,
    input  gtg_ctl_t                     ctl_i,
    input  logic signed [W+18:0]         cx_i,
    input  logic signed [W+18:0]         cy_i,
    input  logic signed [ZW-1:0]         z_i,
    input  logic [2*W-1:0]               rad1_i,
    input  logic [W-1:0]                 root1_i,
    input  logic [W+2:0]                 rem1_i,
    input  logic [2*((W+11)/2)-1:0]      rad2_i,
    input  logic [(W+11)/2-1:0]          root2_i,
    input  logic [(W+11)/2+2:0]          rem2_i,
    output logic                         valid_o,
    input  logic                         ready_i,
    output gtg_ctl_t                     ctl_o,
    output logic signed [W+18:0]         cx_o,
    output logic signed [W+18:0]         cy_o,
    output logic signed [ZW-1:0]         z_o,
    output logic [2*W-1:0]               rad1_o,
    output logic [W-1:0]                 root1_o,
    output logic [W+2:0]                 rem1_o,
    output logic [2*((W+11)/2)-1:0]      rad2_o,
    output logic [(W+11)/2-1:0]          root2_o,
    output logic [(W+11)/2+2:0]          rem2_o
);

    localparam int CW = W + 19;
    localparam int N1 = W;
    localparam int R1 = W + 3;
    localparam int N2 = (W + 11) / 2;
    localparam int M2 = 2 * N2;
    localparam int R2 = N2 + 3;

    logic                  v_reg, en;
    gtg_ctl_t              ctl_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg, cx_next, cy_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic [2*W-1:0]        rad1_reg, rad1_next;
    logic [N1-1:0]         root1_reg, root1_next;
    logic [R1-1:0]         rem1_reg, rem1_next, t1, trial1;
    logic [M2-1:0]         rad2_reg, rad2_next, rad2_src;
    logic [N2-1:0]         root2_reg, root2_next, root2_src;
    logic [R2-1:0]         rem2_reg, rem2_next, rem2_src, t2, trial2;

    assign en      = !v_reg || ready_i;
    assign ready_o = en;

    always_comb
    begin
        cx_next = cx_i;
        cy_next = cy_i;
        z_next  = z_i;
        if (STEP < CORDIC_STEPS)
        begin
            if (!cy_i[CW-1] && (cy_i != '0))
            begin
                cx_next = cx_i + (cy_i >>> STEP);
                cy_next = cy_i - (cx_i >>> STEP);
                z_next  = z_i + $signed({1'b0, atan_q16(STEP)});
            end
            else
            begin
                cx_next = cx_i - (cy_i >>> STEP);
                cy_next = cy_i + (cx_i >>> STEP);
                z_next  = z_i - $signed({1'b0, atan_q16(STEP)});
            end
        end
    end

    // First root: distance from the squared norm, two radicand bits per cell.
    always_comb
    begin
        rad1_next  = rad1_i;
        root1_next = root1_i;
        rem1_next  = rem1_i;
        t1         = {rem1_i[R1-3:0], rad1_i[2*W-1 -: 2]};
        trial1     = {1'b0, root1_i, 2'b01};
        if (STEP < N1)
        begin
            rad1_next = {rad1_i[2*W-3:0], 2'b00};
            if (t1 >= trial1)
            begin
                rem1_next  = t1 - trial1;
                root1_next = {root1_i[N1-2:0], 1'b1};
            end
            else
            begin
                rem1_next  = t1;
                root1_next = {root1_i[N1-2:0], 1'b0};
            end
        end
    end

    // Second root: square root of the distance taken as Q16.10, a Q8.5 result, starting where the first ends.
    always_comb
    begin
        if (STEP == N1)
        begin
            rad2_src  = M2'({root1_i, {FRAC_BITS{1'b0}}});
            root2_src = '0;
            rem2_src  = '0;
        end
        else
        begin
            rad2_src  = rad2_i;
            root2_src = root2_i;
            rem2_src  = rem2_i;
        end
        rad2_next  = rad2_src;
        root2_next = root2_src;
        rem2_next  = rem2_src;
        t2         = {rem2_src[R2-3:0], rad2_src[M2-1 -: 2]};
        trial2     = {1'b0, root2_src, 2'b01};
        if (STEP >= N1 && STEP < N1 + N2)
        begin
            rad2_next = {rad2_src[M2-3:0], 2'b00};
            if (t2 >= trial2)
            begin
                rem2_next  = t2 - trial2;
                root2_next = {root2_src[N2-2:0], 1'b1};
            end
            else
            begin
                rem2_next  = t2;
                root2_next = {root2_src[N2-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_i)
        begin
            ctl_reg   <= ctl_i;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            z_reg     <= z_next;
            rad1_reg  <= rad1_next;
            root1_reg <= root1_next;
            rem1_reg  <= rem1_next;
            rad2_reg  <= rad2_next;
            root2_reg <= root2_next;
            rem2_reg  <= rem2_next;
        end
    end

    assign valid_o = v_reg;
    assign ctl_o   = ctl_reg;
    assign cx_o    = cx_reg;
    assign cy_o    = cy_reg;
    assign z_o     = z_reg;
    assign rad1_o  = rad1_reg;
    assign root1_o = root1_reg;
    assign rem1_o  = rem1_reg;
    assign rad2_o  = rad2_reg;
    assign root2_o = root2_reg;
    assign rem2_o  = rem2_reg;

endmodule

// ----- design/gtg_back.sv -----
// Back end: bearing rounding, command selection, speed scaling and the result register.
// Depends on gtg_pkg.
module gtg_back
    import gtg_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_i,
    output logic                          ready_o,
    input  gtg_ctl_t                      ctl_i,
    input  logic signed [ZW-1:0]          z_i,
    input  logic [(W+11)/2-1:0]           root2_i,
    input  logic [TOL_WIDTH-1:0]          angle_tol,
    input  logic [TOL_WIDTH-1:0]          turn_speed,
    input  logic [TOL_WIDTH-1:0]          drive_gain,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [TOL_WIDTH-1:0]          forward_speed,
    output logic signed [TURN_WIDTH-1:0]  turn_rate,
    output logic                          reached
);

    localparam int N2 = (W + 11) / 2;
    localparam int PW = TOL_WIDTH + N2;

    logic                         v_reg, en;
    logic [TOL_WIDTH-1:0]         fwd_reg, fwd_next;
    logic signed [TURN_WIDTH-1:0] turn_reg, turn_next, ts_pos, ts_neg;
    logic                         reached_reg, reached_next;
    logic [ZW-2:0]                zc, zb;
    logic [ZW-1:0]                zr;
    logic [ZW-7:0]                mag;
    logic [PW-1:0]                prod;
    logic [PW-FRAC_BITS-1:0]      scaled;

    assign en      = !v_reg || out_ready;
    assign ready_o = en;

    always_comb
    begin
        if (z_i[ZW-1])
            zc = '0;
        else if (z_i[ZW-2:0] > HALF_PI_Q16)
            zc = HALF_PI_Q16;
        else
            zc = z_i[ZW-2:0];
        zb  = ctl_i.x_neg ? (PI_Q16 - zc) : zc;
        zr  = {1'b0, zb} + ROUND_Q16;
        mag = zr[ZW-1:6];

        prod   = drive_gain * root2_i;
        scaled = prod[PW-1:FRAC_BITS];
        ts_pos = {1'b0, turn_speed};
        ts_neg = -ts_pos;

        fwd_next     = '0;
        turn_next    = '0;
        reached_next = 1'b0;
        if (ctl_i.near)
        begin
            if (ctl_i.head_over)
                turn_next = ctl_i.head_neg ? ts_neg : ts_pos;
            else
                reached_next = 1'b1;
        end
        else if (ctl_i.x_zero || ({{(TOL_WIDTH-(ZW-6)){1'b0}}, mag} > angle_tol))
            turn_next = ctl_i.y_neg ? ts_neg : ts_pos;
        else if (scaled > (PW-FRAC_BITS)'({TOL_WIDTH{1'b1}}))
            fwd_next = {TOL_WIDTH{1'b1}};
        else
            fwd_next = scaled[TOL_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_i)
        begin
            fwd_reg     <= fwd_next;
            turn_reg    <= turn_next;
            reached_reg <= reached_next;
        end
    end

    assign out_valid     = v_reg;
    assign forward_speed = fwd_reg;
    assign turn_rate     = turn_reg;
    assign reached       = reached_reg;

endmodule

// ----- design/go_to_goal_velocity_controller.sv -----
// Top level of the go-to-goal velocity controller: register file, front end, cell chain, back end.
// Depends on gtg_pkg, gtg_front, gtg_cell and gtg_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  in       | in_valid / in_ready     | goal_x, goal_y, goal_heading
//  out      | out_valid / out_ready   | forward_speed, turn_rate, reached
//  config   | psel, penable, pwrite   | paddr, pwdata, prdata (pready tied high)
//
// One pose enters per cycle while the output is not stalled; the result passes through the
// front end, the cell chain (one cell per root digit) and the back end.
// Every stage holds its transfer while the next one is full, so a stalled output backs up
// stage by stage and in_ready stays high while any stage is empty.
// Reset restores the four tolerance and gain registers and empties the pipeline.
module go_to_goal_velocity_controller
    import gtg_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_WIDTH-1:0]         paddr,
    input  logic [DATA_WIDTH-1:0]         pwdata,
    output logic [DATA_WIDTH-1:0]         prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] goal_x,
    input  logic signed [COORD_WIDTH-1:0] goal_y,
    input  logic signed [HEAD_WIDTH-1:0]  goal_heading,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [TOL_WIDTH-1:0]          forward_speed,
    output logic signed [TURN_WIDTH-1:0]  turn_rate,
    output logic                          reached
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = W + 19;
    localparam int N1 = W;
    localparam int N2 = (W + 11) / 2;
    localparam int M2 = 2 * N2;
    localparam int NC = (N1 + N2 > CORDIC_STEPS) ? N1 + N2 : CORDIC_STEPS;

    logic [TOL_WIDTH-1:0] dist_tol_reg, angle_tol_reg, turn_speed_reg, drive_gain_reg;
    logic                 wr_en;
    reg_index_t           wr_idx;

    logic                 c_valid [NC+1];
    logic                 c_ready [NC+1];
    gtg_ctl_t             c_ctl   [NC+1];
    logic signed [CW-1:0] c_cx    [NC+1];
    logic signed [CW-1:0] c_cy    [NC+1];
    logic signed [ZW-1:0] c_z     [NC+1];
    logic [2*W-1:0]       c_rad1  [NC+1];
    logic [N1-1:0]        c_root1 [NC+1];
    logic [W+2:0]         c_rem1  [NC+1];
    logic [M2-1:0]        c_rad2  [NC+1];
    logic [N2-1:0]        c_root2 [NC+1];
    logic [N2+2:0]        c_rem2  [NC+1];
    logic [W-1:0]         f_ux, f_uy;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_tol_reg   <= 15'd307;
            angle_tol_reg  <= 15'd614;
            turn_speed_reg <= 15'd307;
            drive_gain_reg <= 15'd512;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_DIST_TOL:  dist_tol_reg   <= pwdata[TOL_WIDTH-1:0];
                REG_ANGLE_TOL: angle_tol_reg  <= pwdata[TOL_WIDTH-1:0];
                REG_TURN_SPD:  turn_speed_reg <= pwdata[TOL_WIDTH-1:0];
                REG_DRV_GAIN:  drive_gain_reg <= pwdata[TOL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_DIST_TOL:  prdata = DATA_WIDTH'(dist_tol_reg);
            REG_ANGLE_TOL: prdata = DATA_WIDTH'(angle_tol_reg);
            REG_TURN_SPD:  prdata = DATA_WIDTH'(turn_speed_reg);
            REG_DRV_GAIN:  prdata = DATA_WIDTH'(drive_gain_reg);
            default:       prdata = '0;
        endcase
    end

    gtg_front #(.W(W)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_i      (in_valid),
        .ready_o      (in_ready),
        .goal_x       (goal_x),
        .goal_y       (goal_y),
        .goal_heading (goal_heading),
        .dist_tol     (dist_tol_reg),
        .angle_tol    (angle_tol_reg),
        .valid_o      (c_valid[0]),
        .ready_i      (c_ready[0]),
        .ctl_o        (c_ctl[0]),
        .ux_o         (f_ux),
        .uy_o         (f_uy),
        .s_o          (c_rad1[0])
    );

    // The CORDIC starts on |x| and |y| scaled to Q.16; both roots start empty.
    assign c_cx[0]    = $signed({3'b000, f_ux, {CORDIC_FRAC{1'b0}}});
    assign c_cy[0]    = $signed({3'b000, f_uy, {CORDIC_FRAC{1'b0}}});
    assign c_z[0]     = '0;
    assign c_root1[0] = '0;
    assign c_rem1[0]  = '0;
    assign c_rad2[0]  = '0;
    assign c_root2[0] = '0;
    assign c_rem2[0]  = '0;

    for (genvar k = 0; k < NC; k++)
    begin : g_chain
        gtg_cell #(.W(W), .STEP(k)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .valid_i (c_valid[k]),
            .ready_o (c_ready[k]),
            .ctl_i   (c_ctl[k]),
            .cx_i    (c_cx[k]),
            .cy_i    (c_cy[k]),
            .z_i     (c_z[k]),
            .rad1_i  (c_rad1[k]),
            .root1_i (c_root1[k]),
            .rem1_i  (c_rem1[k]),
            .rad2_i  (c_rad2[k]),
            .root2_i (c_root2[k]),
            .rem2_i  (c_rem2[k]),
            .valid_o (c_valid[k+1]),
            .ready_i (c_ready[k+1]),
            .ctl_o   (c_ctl[k+1]),
            .cx_o    (c_cx[k+1]),
            .cy_o    (c_cy[k+1]),
            .z_o     (c_z[k+1]),
            .rad1_o  (c_rad1[k+1]),
            .root1_o (c_root1[k+1]),
            .rem1_o  (c_rem1[k+1]),
            .rad2_o  (c_rad2[k+1]),
            .root2_o (c_root2[k+1]),
            .rem2_o  (c_rem2[k+1])
        );
    end

    gtg_back #(.W(W)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_i       (c_valid[NC]),
        .ready_o       (c_ready[NC]),
        .ctl_i         (c_ctl[NC]),
        .z_i           (c_z[NC]),
        .root2_i       (c_root2[NC]),
        .angle_tol     (angle_tol_reg),
        .turn_speed    (turn_speed_reg),
        .drive_gain    (drive_gain_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .forward_speed (forward_speed),
        .turn_rate     (turn_rate),
        .reached       (reached)
    );

    // An empty result register lets every stage move, so input is never refused then.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused while the result register is empty");

    a_reached_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reached) |-> (forward_speed == '0 && turn_rate == '0))
        else $error("goal reached but a motion command is given");

    a_drive_or_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && forward_speed != '0) |-> (turn_rate == '0 && !reached))
        else $error("driving forward while turning");

    a_turn_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (turn_rate == '0 || turn_rate == $signed({1'b0, turn_speed_reg})
                       || turn_rate == -$signed({1'b0, turn_speed_reg})))
        else $error("turn rate differs from the configured turn speed");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the go-to-goal velocity controller.
// Depends on gtg_pkg and go_to_goal_velocity_controller, and through it on the other design files.
// A local model predicts each velocity command and the monitor compares it field by field.
module testbench;
    import gtg_pkg::*;

    localparam int CW = 16;
    localparam int PIPE_DRAIN = 40;

    typedef struct {
        logic [TOL_WIDTH-1:0]  fwd;
        logic [TURN_WIDTH-1:0] turn;
        logic                  done;
    } vel_cmd_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ADDR_WIDTH-1:0]        paddr;
    logic [DATA_WIDTH-1:0]        pwdata;
    logic [DATA_WIDTH-1:0]        prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [CW-1:0]         goal_x;
    logic signed [CW-1:0]         goal_y;
    logic signed [HEAD_WIDTH-1:0] goal_heading;
    logic                         out_valid;
    logic                         out_ready;
    logic [TOL_WIDTH-1:0]         forward_speed;
    logic signed [TURN_WIDTH-1:0] turn_rate;
    logic                         reached;

    vel_cmd_t pending_cmds[$];
    longint   dist_tol_r;
    longint   angle_tol_r;
    longint   turn_spd_r;
    longint   drive_gain_r;
    longint   atan_tab[CORDIC_STEPS];
    int       mismatches;
    int       poses_sent;
    int       cmds_checked;
    int       reg_writes;
    int       hold_left;
    bit       idling_on;

    go_to_goal_velocity_controller #(.COORD_WIDTH(CW)) u_top (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .goal_x(goal_x), .goal_y(goal_y),
        .goal_heading(goal_heading), .out_valid(out_valid), .out_ready(out_ready),
        .forward_speed(forward_speed), .turn_rate(turn_rate), .reached(reached)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Bearing magnitude in Q3.10 from a vectoring CORDIC in Q.16, folded for goals behind.
    function automatic longint bearing_q10(input longint x, input longint y);
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        cx = (x < 0 ? -x : x) << 16;
        cy = (y < 0 ? -y : y) << 16;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx = cx + dx; cy = cy - dy; z = z + atan_tab[i];
            end
            else
            begin
                cx = cx - dx; cy = cy + dy; z = z - atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 102944) z = 102944;
        if (x < 0) z = 205887 - z;
        return (z + 32) >> 6;
    endfunction

    function automatic vel_cmd_t predict_command(input longint x, input longint y,
                                                 input longint h);
        vel_cmd_t c;
        longint unsigned s;
        longint unsigned d;
        longint unsigned r;
        longint unsigned f;
        longint turn;
        longint ah;
        s = x * x + y * y;
        f = 0;
        turn = 0;
        c.done = 1'b0;
        if (s < dist_tol_r * dist_tol_r)
        begin
            ah = h < 0 ? -h : h;
            if (ah > angle_tol_r) turn = h < 0 ? -turn_spd_r : turn_spd_r;
            else c.done = 1'b1;
        end
        else if (x == 0)
        begin
            turn = y < 0 ? -turn_spd_r : turn_spd_r;
        end
        else if (bearing_q10(x, y) > angle_tol_r)
        begin
            turn = y < 0 ? -turn_spd_r : turn_spd_r;
        end
        else
        begin
            d = int_sqrt(s);
            r = int_sqrt(d << 10);
            f = (drive_gain_r * r) >> 10;
            if (f > 32767) f = 32767;
        end
        c.fwd = f[TOL_WIDTH-1:0];
        c.turn = turn[TURN_WIDTH-1:0];
        return c;
    endfunction

    // Monitor: every output transfer is compared with the oldest prediction.
    always @(posedge clk)
    begin
        vel_cmd_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected command fwd=%0d turn=%0d reached=%0b",
                                               forward_speed, turn_rate, reached);
            end
            else
            begin
                e = pending_cmds.pop_front();
                cmds_checked++;
                if (e.fwd !== forward_speed || e.turn !== turn_rate || e.done !== reached)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: fwd %0d/%0d turn %0d/%0d reached %0b/%0b (exp/act)",
                                 e.fwd, forward_speed, $signed(e.turn), turn_rate,
                                 e.done, reached);
                end
            end
        end
    end

    // Receiver: random stall bursts plus an optional long hold-off.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_pose(input longint x, input longint y, input longint h);
        int gap;
        goal_x = x[CW-1:0];
        goal_y = y[CW-1:0];
        goal_heading = h[HEAD_WIDTH-1:0];
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready) break;
        end
        pending_cmds.insert(pending_cmds.size(), predict_command(x, y, h));
        poses_sent++;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_cmds.size() != 0) @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_WIDTH-1:0] value);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = ADDR_WIDTH'(4 * int'(idx));
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_DIST_TOL:  dist_tol_r = value[TOL_WIDTH-1:0];
            REG_ANGLE_TOL: angle_tol_r = value[TOL_WIDTH-1:0];
            REG_TURN_SPD:  turn_spd_r = value[TOL_WIDTH-1:0];
            REG_DRV_GAIN:  drive_gain_r = value[TOL_WIDTH-1:0];
            default:       ;
        endcase
        reg_writes++;
    endtask

    task automatic set_all(input longint dt, input longint at, input longint ts,
                           input longint dg);
        wait_idle();
        // Upper bits are random so the register masking is exercised too.
        write_reg(REG_DIST_TOL,  {17'($urandom_range(0, 131071)), dt[TOL_WIDTH-1:0]});
        write_reg(REG_ANGLE_TOL, {17'($urandom_range(0, 131071)), at[TOL_WIDTH-1:0]});
        write_reg(REG_TURN_SPD,  {17'($urandom_range(0, 131071)), ts[TOL_WIDTH-1:0]});
        write_reg(REG_DRV_GAIN,  {17'($urandom_range(0, 131071)), dg[TOL_WIDTH-1:0]});
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 1) ? 32767 : -32768;
            2, 3:    return longint'($urandom_range(0, 800)) - 400;
            default: return longint'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic test_directed();
        send_pose(0, 0, 0);
        send_pose(100, -50, 3217);
        send_pose(-20, 30, -3217);
        send_pose(10, 10, 614);
        send_pose(10, 10, -615);
        send_pose(32767, 0, 0);
        send_pose(-32768, 0, 0);
        send_pose(-32768, -32768, 0);
        send_pose(32767, 32767, 0);
        send_pose(32767, -32768, 1234);
        send_pose(0, 5000, 0);
        send_pose(0, -5000, 0);
        send_pose(-3000, 0, 0);
        send_pose(3000, 0, -2048);
        send_pose(3000, 1700, 0);
        send_pose(3000, -1700, 0);
        send_pose(-3000, 100, 0);
        send_pose(-3000, -100, 1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pose(rand_coord(), rand_coord(), longint'($urandom_range(0, 6434)) - 3217);
    endtask

    task automatic test_extreme_settings();
        // Zero tolerances: the origin no longer counts as reached, and with zero turn speed every turn command is zero.
        set_all(0, 0, 0, 0);
        send_pose(0, 0, 0);
        send_pose(0, 0, -3217);
        send_pose(500, 0, 0);
        test_random(60);
        // Widest tolerances, full speed and full gain for saturation.
        set_all(32767, 32767, 32767, 32767);
        send_pose(-32768, -32768, 3217);
        test_random(40);
        set_all(5, 32767, 32767, 32767);
        send_pose(32767, 32767, 0);
        send_pose(-32768, 0, 0);
        test_random(60);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_left = 300;
        for (int i = 0; i < 60; i++)
            send_pose(rand_coord(), rand_coord(), longint'($urandom_range(0, 6434)) - 3217);
    endtask

    initial
    begin
        atan_tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        dist_tol_r = 307; angle_tol_r = 614; turn_spd_r = 307; drive_gain_r = 512;
        mismatches = 0; poses_sent = 0; cmds_checked = 0; reg_writes = 0;
        hold_left = 0; idling_on = 1'b1;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; goal_x = '0; goal_y = '0; goal_heading = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_random(150);
        test_backpressure();
        test_extreme_settings();
        set_all($urandom_range(0, 3000), $urandom_range(0, 3217),
                $urandom_range(0, 32767), $urandom_range(0, 32767));
        test_directed();
        test_random(200);
        set_all(307, 614, 307, 512);
        idling_on = 1'b0;
        test_random(150);

        wait_idle();
        $display("Sent %0d poses across %0d register writes, checked %0d commands,",
                 poses_sent, reg_writes, cmds_checked);
        $display("including zero and full-scale settings and a long output hold-off.");
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/gtg_pkg.sv
design/gtg_front.sv
design/gtg_cell.sv
design/gtg_back.sv
design/go_to_goal_velocity_controller.sv
dv/testbench.sv
